// ----- design/median_filter_window_3x3_5x5_top_defines.svh -----
// ----------------------------------------------------------------------------
// median filter assertion macros
// shared property wrappers for the checker, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_WINDOW_3X3_5X5_TOP_DEFINES_SVH
`define MEDIAN_FILTER_WINDOW_3X3_5X5_TOP_DEFINES_SVH

// same-cycle implication
`define MF35_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MF35_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mf35_pkg.sv -----
// ----------------------------------------------------------------------------
// median filter package
// shared widths, window geometry, codes and payload types
// ----------------------------------------------------------------------------
package mf35_pkg;

  // pixel and window geometry
  localparam int PIX_BITS  = 8;
  localparam int WIN_COLS  = 5;
  localparam int WIN_ROWS  = 5;
  localparam int WIN_N     = WIN_COLS * WIN_ROWS;
  localparam int MED_RANK  = WIN_N / 2;
  localparam int RANK_BITS = $clog2(WIN_N);

  // 3x3 sub-window placement inside the 5x5 window
  localparam int SMALL_COL_LO = 2;
  localparam int SMALL_ROW_LO = 1;
  localparam int SMALL_ROW_HI = 3;
  // padding elements forced to the minimum in 3x3 mode, the rest go to maximum
  localparam int PAD_LOW_N    = 8;

  // column counter
  localparam int SEEN_BITS = 3;
  localparam int SEEN_MAX  = 5;
  localparam int FULL_3X3  = 3;
  localparam int FULL_5X5  = 5;

  // window mode codes
  localparam logic MODE_3X3 = 1'b0;
  localparam logic MODE_5X5 = 1'b1;

  // register interface
  localparam int   ADDR_BITS       = 3;
  localparam int   DATA_BITS       = 32;
  localparam logic REG_WINDOW_MODE = 1'b0;

  typedef logic [PIX_BITS-1:0]  pix_t;
  typedef pix_t [WIN_ROWS-1:0]  col_t;
  typedef col_t [WIN_COLS-1:0]  win_t;
  typedef logic [SEEN_BITS-1:0] seen_t;

  typedef struct packed {
    pix_t pixel_row0;
    pix_t pixel_row1;
    pix_t pixel_row2;
    pix_t pixel_row3;
    pix_t pixel_row4;
    logic row_start;
  } in_t;

  typedef struct packed {
    pix_t median_value;
    logic window_full;
  } out_t;

endpackage

// ----- design/mf35_cfg.sv -----
// ----------------------------------------------------------------------------
// median filter configuration registers
// apb-style write and read of the window mode register
// ----------------------------------------------------------------------------
module mf35_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mf35_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mf35_pkg::DATA_BITS-1:0] pwdata,
  output logic [mf35_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  output logic                          window_mode
);

  logic sel_mode;

  // register decode on the word index
  assign sel_mode = (paddr[mf35_pkg::ADDR_BITS-1] == mf35_pkg::REG_WINDOW_MODE);
  assign pready   = 1'b1;

  // mode register, written in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      window_mode <= mf35_pkg::MODE_3X3;
    end else if (psel && penable && pwrite && pready && sel_mode) begin
      window_mode <= pwdata[0];
    end
  end

  // read data
  always_comb begin
    prdata = '0;
    if (sel_mode) begin
      prdata[0] = window_mode;
    end
  end

endmodule

// ----- design/mf35_window.sv -----
// ----------------------------------------------------------------------------
// median filter window store
// five-column shift register, column counter and pipeline valid flag
// ----------------------------------------------------------------------------
module mf35_window (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  mf35_pkg::in_t   item,
  input  logic            advance,
  output mf35_pkg::win_t  win,
  output mf35_pkg::seen_t seen,
  output logic            valid
);

  mf35_pkg::col_t  column;
  mf35_pkg::seen_t seen_next;

  // incoming column, row 0 at the top
  assign column = {item.pixel_row4, item.pixel_row3, item.pixel_row2,
                   item.pixel_row1, item.pixel_row0};

  // shift in the newest column on every accepted transaction
  always_ff @(posedge clk) begin
    if (take) begin
      win[mf35_pkg::WIN_COLS-2:0] <= win[mf35_pkg::WIN_COLS-1:1];
      win[mf35_pkg::WIN_COLS-1]   <= column;
    end
  end

  // columns since row start, saturating
  always_comb begin
    priority if (item.row_start) begin
      seen_next = mf35_pkg::seen_t'(1);
    end else if (seen < mf35_pkg::seen_t'(mf35_pkg::SEEN_MAX)) begin
      seen_next = seen + mf35_pkg::seen_t'(1);
    end else begin
      seen_next = seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (take) begin
      seen <= seen_next;
    end
  end

  // window stage holds a transaction until the result stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

endmodule

// ----- design/mf35_median.sv -----
// ----------------------------------------------------------------------------
// median filter rank selector
// picks the middle element of 25 by counting, for each, the elements before it
// ----------------------------------------------------------------------------
module mf35_median (
  input  mf35_pkg::win_t win,
  input  logic           mode,
  output mf35_pkg::pix_t median
);

  mf35_pkg::pix_t           elem [mf35_pkg::WIN_N];
  logic [mf35_pkg::WIN_N-1:0] hit;

  // element list: in 3x3 mode the unused places become eight minimum and
  // eight maximum values, so the middle of all 25 is the middle of the nine
  always_comb begin
    int k;
    for (int c = 0; c < mf35_pkg::WIN_COLS; c++) begin
      for (int r = 0; r < mf35_pkg::WIN_ROWS; r++) begin
        k = c * mf35_pkg::WIN_ROWS + r;
        if (mode == mf35_pkg::MODE_5X5 ||
            (c >= mf35_pkg::SMALL_COL_LO &&
             r >= mf35_pkg::SMALL_ROW_LO && r <= mf35_pkg::SMALL_ROW_HI)) begin
          elem[k] = win[c][r];
        end else if (k < mf35_pkg::PAD_LOW_N) begin
          elem[k] = '0;
        end else begin
          elem[k] = '1;
        end
      end
    end
  end

  // rank of each element in a total order, ties broken by position
  for (genvar i = 0; i < mf35_pkg::WIN_N; i++) begin : g_rank
    logic [mf35_pkg::WIN_N-1:0]   ahead;
    logic [mf35_pkg::RANK_BITS-1:0] rank;

    always_comb begin
      for (int j = 0; j < mf35_pkg::WIN_N; j++) begin
        ahead[j] = (elem[j] < elem[i]) || ((elem[j] == elem[i]) && (j < i));
      end
    end

    assign rank   = mf35_pkg::RANK_BITS'($countones(ahead));
    assign hit[i] = (rank == mf35_pkg::RANK_BITS'(mf35_pkg::MED_RANK));
  end

  // exactly one element holds the middle rank
  always_comb begin
    median = '0;
    for (int i = 0; i < mf35_pkg::WIN_N; i++) begin
      if (hit[i]) begin
        median = median | elem[i];
      end
    end
  end

endmodule

// ----- design/median_filter_window_3x3_5x5_top.sv -----
// path: window register, rank compare, then result register
// throughput: one column per cycle unless a result is stalled; the window and
//   result registers hold one item each, the 25-way rank compare sits between
// reset: synchronous rst clears the column count, valid flags and the mode
//   register (3x3); the column store is not cleared, stale columns never count
// ----------------------------------------------------------------------------
// median filter top level
// streaming 3x3 / 5x5 median over incoming pixel columns
// ----------------------------------------------------------------------------
module median_filter_window_3x3_5x5_top (
  input  logic                          clk,
  input  logic                          rst,
  // column input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mf35_pkg::in_t                 in_item,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output mf35_pkg::out_t                out_item,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mf35_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mf35_pkg::DATA_BITS-1:0] pwdata,
  output logic [mf35_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  logic            window_mode;
  logic            in_take;
  logic            res_take;
  logic            win_valid;
  logic            win_advance;
  logic            full;
  mf35_pkg::win_t  win;
  mf35_pkg::seen_t seen;
  mf35_pkg::pix_t  median;

  mf35_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_mode (window_mode)
  );

  // handshake: result stage frees when empty or being read
  assign res_take    = !out_valid || !out_stall;
  assign win_advance = win_valid && res_take;
  assign in_stall    = win_valid && !res_take;
  assign in_take     = in_valid && !in_stall;

  mf35_window u_window (
    .clk     (clk),
    .rst     (rst),
    .take    (in_take),
    .item    (in_item),
    .advance (win_advance),
    .win     (win),
    .seen    (seen),
    .valid   (win_valid)
  );

  mf35_median u_median (
    .win    (win),
    .mode   (window_mode),
    .median (median)
  );

  // enough columns for the selected window
  assign full = (window_mode == mf35_pkg::MODE_5X5) ?
                (seen >= mf35_pkg::seen_t'(mf35_pkg::FULL_5X5)) :
                (seen >= mf35_pkg::seen_t'(mf35_pkg::FULL_3X3));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (win_advance) begin
      out_item.median_value <= full ? median : '0;
      out_item.window_full  <= full;
    end
  end

endmodule

// ----- design/mf35_checker.sv -----
// ----------------------------------------------------------------------------
// median filter port checker
// port-level properties of the result channel and its back-pressure
// ----------------------------------------------------------------------------
`include "median_filter_window_3x3_5x5_top_defines.svh"

module mf35_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input mf35_pkg::out_t out_item,
  input logic           psel,
  input logic           pready
);

  // a stalled result holds
  `MF35_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")

  // a window that is not full reports zero
  `MF35_ASSERT_NOW(a_empty_zero, out_valid && !out_item.window_full, out_item.median_value == '0, "median not zero for partial window")

  // input back-pressure only comes from a blocked result
  `MF35_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with free result stage")

  // configuration port never waits
  `MF35_ASSERT_NOW(a_pready, psel, pready, "pready low during transfer")

endmodule

bind median_filter_window_3x3_5x5_top mf35_checker u_checker (.*);
